@@ design/ilha_pkg.sv @@
// Shared types and constants of the implicit-list heap allocator.
`default_nettype none
package ilha_pkg;

  localparam logic [1:0] MODE_INIT  = 2'd0;
  localparam logic [1:0] MODE_ALLOC = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;

  localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;
  localparam logic [31:0] TAG_USED  = 32'd1;
  localparam logic [31:0] MIN_BLOCK = 32'd16;

  // One cycle of heap memory traffic: at most one write and one read.
  typedef struct packed {
    logic        we;
    logic [31:0] waddr;
    logic [31:0] wdata;
    logic [31:0] raddr;
  } mem_req_t;

endpackage
`default_nettype wire

@@ design/implicit_list_heap_allocator_core.sv @@
// Boundary-tag heap allocator with first-fit search over an implicit block list.
//
// Input channel (in_valid/in_ready) carries mode, request_bytes and
// block_address; output channel (out_valid/out_ready) returns one item per
// input: payload_address and success. Modes: 0 initialize, 1 allocate, 2 free.
// Items are processed one at a time by a sequencer around a single heap
// memory with a registered read port. A free merges with free neighbours;
// an allocate walks the headers first-fit, splits the block when it is
// large enough and grows the heap when no block fits. A zero-size allocate
// and an unused mode go straight to the result. The sequencer returns to
// idle before the next item is taken. The walk is bounded by HEAP_WORDS
// steps.
// A new item is taken while the previous result still waits at the output;
// the sequencer holds its finished item until the output register is free,
// so a stalled receiver stops the block after at most one queued item.
// Reset clears the break, the list start and the control state; heap words
// are undefined until an initialize writes them.
`default_nettype none
module implicit_list_heap_allocator_core #(
  parameter int HEAP_BYTES  = 65536,
  parameter int CHUNK_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [15:0] request_bytes,
  input  wire logic [15:0] block_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      payload_address,
  output logic             success
);

  localparam int HEAP_LIMIT = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
  localparam int HEAP_WORDS = HEAP_LIMIT / 4;
  localparam int SW = $clog2(HEAP_WORDS + 1);
  localparam logic [31:0] LIMIT = 32'(HEAP_LIMIT);
  localparam logic [31:0] CHUNK = 32'(CHUNK_BYTES);

  localparam logic [4:0] S_IDLE = 5'd0,  S_IW0 = 5'd1,   S_IW1 = 5'd2,   S_IW2 = 5'd3,
                         S_IW3 = 5'd4,   S_AST = 5'd5,   S_FRD = 5'd6,   S_FCK = 5'd7,
                         S_NOF = 5'd8,   S_EXT = 5'd9,   S_EXF = 5'd10,  S_EXN = 5'd11,
                         S_MR0 = 5'd12,  S_MR1 = 5'd13,  S_MR2 = 5'd14,  S_MR3 = 5'd15,
                         S_MD  = 5'd16,  S_MW2 = 5'd17,  S_MEND = 5'd18, S_CRD = 5'd19,
                         S_CD  = 5'd20,  S_CW2 = 5'd21,  S_CW3 = 5'd22,  S_CW4 = 5'd23,
                         S_FR  = 5'd24,  S_FD  = 5'd25,  S_FW2 = 5'd26,  S_DONE = 5'd27;

  logic [4:0]  st;
  logic [1:0]  op;
  logic [15:0] req_b, addr_b;
  logic [31:0] asize, bp, ext_b, esize, psz, psize, size, w2_addr, w2_data, bsize;
  logic        pa, split, res_ok;
  logic [15:0] res_pay;
  logic [SW-1:0] steps;
  logic [16:0] brk;
  logic [15:0] lstart;

  ilha_pkg::mem_req_t mreq;
  logic [31:0] rdata;

  ilha_mem #(.DEPTH(HEAP_WORDS)) u_mem (.clk(clk), .req(mreq), .rdata(rdata));

  // derived values
  logic [31:0] rsize, ewords, esize_c, mg_new, mg_addr, asize_c;
  logic        grow_fail, na;

  always_comb begin
    rsize   = rdata & ilha_pkg::SIZE_MASK;
    na      = rdata[0];
    ewords  = ext_b >> 2;
    esize_c = (ewords + {31'd0, ewords[0]}) << 2;
    grow_fail = (32'(brk) > LIMIT) || (esize_c > LIMIT - 32'(brk));
    asize_c = (request_bytes <= 16'd8) ? ilha_pkg::MIN_BLOCK
            : ((({16'd0, request_bytes} + 32'd7) & ilha_pkg::SIZE_MASK) + 32'd8);
    if (pa) begin
      mg_new  = size + rsize;
      mg_addr = bp - 32'd4;
    end else if (na) begin
      mg_new  = size + psize;
      mg_addr = bp + size - 32'd8;
    end else begin
      mg_new  = size + psize + rsize;
      mg_addr = bp - psz - 32'd4;
    end
  end

  always_comb begin
    mreq.we    = 1'b0;
    mreq.waddr = bp - 32'd4;
    mreq.wdata = 32'd0;
    mreq.raddr = bp - 32'd4;
    unique case (st)
      S_IW0: begin mreq.we = 1'b1; mreq.waddr = 32'd0;  mreq.wdata = 32'd0; end
      S_IW1: begin mreq.we = 1'b1; mreq.waddr = 32'd4;  mreq.wdata = 32'd9; end
      S_IW2: begin mreq.we = 1'b1; mreq.waddr = 32'd8;  mreq.wdata = 32'd9; end
      S_IW3: begin mreq.we = 1'b1; mreq.waddr = 32'd12; mreq.wdata = ilha_pkg::TAG_USED; end
      S_EXT: begin
        mreq.we = !grow_fail; mreq.waddr = 32'(brk) - 32'd4; mreq.wdata = esize_c;
      end
      S_EXF: begin mreq.we = 1'b1; mreq.waddr = bp + esize - 32'd8; mreq.wdata = esize; end
      S_EXN: begin
        mreq.we = 1'b1; mreq.waddr = bp + esize - 32'd4; mreq.wdata = ilha_pkg::TAG_USED;
      end
      S_MR0: mreq.raddr = bp - 32'd8;
      S_MR1: mreq.raddr = bp - rsize - 32'd4;
      S_MR2: mreq.raddr = bp - 32'd4;
      S_MR3: mreq.raddr = bp + rsize - 32'd4;
      S_MD: begin
        mreq.we = !(pa && na); mreq.waddr = mg_addr; mreq.wdata = mg_new;
      end
      S_MW2: begin mreq.we = 1'b1; mreq.waddr = w2_addr; mreq.wdata = w2_data; end
      S_CD: begin
        mreq.we = 1'b1; mreq.waddr = bp - 32'd4;
        mreq.wdata = (rsize >= ilha_pkg::MIN_BLOCK + asize) ? (asize | ilha_pkg::TAG_USED)
                                                            : (rsize | ilha_pkg::TAG_USED);
      end
      S_CW2: begin
        mreq.we = 1'b1;
        mreq.waddr = split ? bp + asize - 32'd8 : bp + bsize - 32'd8;
        mreq.wdata = (split ? asize : bsize) | ilha_pkg::TAG_USED;
      end
      S_CW3: begin mreq.we = 1'b1; mreq.waddr = bp + asize - 32'd4; mreq.wdata = bsize - asize; end
      S_CW4: begin mreq.we = 1'b1; mreq.waddr = bp + bsize - 32'd8; mreq.wdata = bsize - asize; end
      S_FR:  mreq.raddr = {16'd0, addr_b} - 32'd4;
      S_FD:  begin mreq.we = 1'b1; mreq.waddr = {16'd0, addr_b} - 32'd4; mreq.wdata = rsize; end
      S_FW2: begin mreq.we = 1'b1; mreq.waddr = {16'd0, addr_b} + size - 32'd8; mreq.wdata = size; end
      default: ;
    endcase
  end

  assign in_ready = (st == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      brk       <= 17'd0;
      lstart    <= 16'd0;
      steps     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (st == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: if (in_valid) begin
          op      <= mode;
          req_b   <= request_bytes;
          addr_b  <= block_address;
          asize   <= asize_c;
          res_ok  <= 1'b0;
          res_pay <= 16'd0;
          case (mode)
            ilha_pkg::MODE_INIT:  st <= S_IW0;
            ilha_pkg::MODE_ALLOC: st <= S_AST;
            ilha_pkg::MODE_FREE:  st <= S_FR;
            default:              st <= S_DONE;
          endcase
        end
        S_IW0: st <= S_IW1;
        S_IW1: st <= S_IW2;
        S_IW2: st <= S_IW3;
        S_IW3: begin
          lstart <= 16'd8;
          brk    <= 17'd16;
          ext_b  <= CHUNK;
          st     <= S_EXT;
        end
        S_AST: begin
          bp    <= {16'd0, lstart};
          steps <= '0;
          st    <= (req_b == 16'd0) ? S_DONE : S_FRD;
        end
        S_FRD: st <= (steps == SW'(HEAP_WORDS)) ? S_NOF : S_FCK;
        S_FCK: begin
          if (rsize == 32'd0) begin
            st <= S_NOF;
          end else if (!rdata[0] && rsize >= asize) begin
            st <= S_CRD;
          end else begin
            bp    <= bp + rsize;
            steps <= steps + SW'(1);
            st    <= S_FRD;
          end
        end
        S_NOF: begin
          ext_b <= (CHUNK > asize) ? CHUNK : asize;
          st    <= S_EXT;
        end
        S_EXT: begin
          if (grow_fail) begin
            st <= S_DONE;
          end else begin
            bp  <= 32'(brk);
            brk <= 17'(32'(brk) + esize_c);
            st  <= S_EXF;
          end
        end
        S_EXF: st <= S_EXN;
        S_EXN: st <= S_MR0;
        S_MR0: st <= S_MR1;
        S_MR1: begin psz <= rsize; st <= S_MR2; end
        S_MR2: begin pa <= rdata[0]; psize <= rsize; st <= S_MR3; end
        S_MR3: begin size <= rsize; st <= S_MD; end
        S_MD: begin
          w2_data <= mg_new;
          if (pa && na) begin
            st <= S_MEND;
          end else if (pa) begin
            w2_addr <= bp + mg_new - 32'd8;
            st      <= S_MW2;
          end else begin
            w2_addr <= na ? bp - psz - 32'd4 : bp + size + rsize - 32'd8;
            bp      <= bp - psz;
            st      <= S_MW2;
          end
        end
        S_MW2: st <= S_MEND;
        S_MEND: begin
          if (op == ilha_pkg::MODE_ALLOC) begin
            st <= S_CRD;
          end else begin
            res_ok <= 1'b1;
            st     <= S_DONE;
          end
        end
        S_CRD: st <= S_CD;
        S_CD: begin
          bsize <= rsize;
          split <= rsize >= ilha_pkg::MIN_BLOCK + asize;
          st    <= S_CW2;
        end
        S_CW2: begin
          if (split) begin
            st <= S_CW3;
          end else begin
            res_ok <= 1'b1; res_pay <= bp[15:0]; st <= S_DONE;
          end
        end
        S_CW3: st <= S_CW4;
        S_CW4: begin res_ok <= 1'b1; res_pay <= bp[15:0]; st <= S_DONE; end
        S_FR: begin bp <= {16'd0, addr_b}; st <= S_FD; end
        S_FD: begin size <= rsize; st <= S_FW2; end
        S_FW2: st <= S_MR0;
        S_DONE: if (!out_valid || out_ready) begin
          payload_address <= res_pay;
          success         <= res_ok;
          st              <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // extension size is kept for the footer and epilogue writes
  always_ff @(posedge clk) begin
    if (st == S_EXT) esize <= esize_c;
  end

`ifndef SYNTHESIS
  a_brk_bound: assert property (@(posedge clk) disable iff (rst) 32'(brk) <= LIMIT)
    else $error("break past heap limit");
  a_pay_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && payload_address != 16'd0 |-> success)
    else $error("payload returned without success");
  a_steps: assert property (@(posedge clk) disable iff (rst) steps <= SW'(HEAP_WORDS))
    else $error("search walk overran bound");
`endif

endmodule
`default_nettype wire

@@ design/ilha_mem.sv @@
// Heap word memory addressed by byte offset; out-of-range reads give an allocated zero tag.
`default_nettype none
module ilha_mem #(
  parameter int DEPTH = 16384
) (
  input  wire logic              clk,
  input  wire ilha_pkg::mem_req_t req,
  output logic [31:0]            rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [31:0] mem [DEPTH];
  logic [31:0] q;
  logic        oor;

  logic w_in, r_in;
  assign w_in = req.waddr[31:2] < 30'(DEPTH);
  assign r_in = req.raddr[31:2] < 30'(DEPTH);

  always_ff @(posedge clk) begin
    if (req.we && w_in) begin
      mem[req.waddr[AW+1:2]] <= req.wdata;
    end
    q   <= mem[req.raddr[AW+1:2]];
    oor <= !r_in;
  end

  assign rdata = oor ? ilha_pkg::TAG_USED : q;

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the implicit-list first-fit heap allocator core.
`timescale 1ns / 100ps
module testbench;

  localparam int unsigned HEAP_LIMIT = 65536;
  localparam int unsigned HEAP_WORDS = HEAP_LIMIT / 4;
  localparam int unsigned CHUNK      = 4096;
  localparam int unsigned CYCLE_LIMIT = 40000000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  mode;
  logic [15:0] request_bytes;
  logic [15:0] block_address;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] payload_address;
  logic        success;

  implicit_list_heap_allocator_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .request_bytes(request_bytes), .block_address(block_address),
    .out_valid(out_valid), .out_ready(out_ready),
    .payload_address(payload_address), .success(success)
  );

  typedef struct packed {
    logic [15:0] payload;
    logic        ok;
  } alloc_result_t;

  // shadow heap
  logic [31:0] heap_mem [0:HEAP_WORDS-1];
  int unsigned brk;
  int unsigned list_head;

  alloc_result_t pending_results[$];
  int unsigned   live_blocks[$];
  bit            heap_ready;
  int unsigned   errors, items_sent, results_seen, cycle_count;
  int unsigned   n_alloc_ok, n_alloc_fail, n_free, n_init;
  bit            hold_off;
  int unsigned   hold_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] tag_rd(int unsigned a);
    if ((a >> 2) >= HEAP_WORDS) return 32'd1;
    return heap_mem[a >> 2];
  endfunction

  function automatic void tag_wr(int unsigned a, logic [31:0] v);
    if ((a >> 2) < HEAP_WORDS) heap_mem[a >> 2] = v;
  endfunction

  function automatic int unsigned sz(int unsigned a);
    return tag_rd(a) & ilha_pkg::SIZE_MASK;
  endfunction

  function automatic bit used(int unsigned a);
    return (tag_rd(a) & ilha_pkg::TAG_USED) != 32'd0;
  endfunction

  function automatic int unsigned next_bp(int unsigned bp);
    return bp + sz(bp - 4);
  endfunction

  function automatic int unsigned prev_bp(int unsigned bp);
    return bp - sz(bp - 8);
  endfunction

  function automatic int unsigned foot(int unsigned bp);
    return bp + sz(bp - 4) - 8;
  endfunction

  function automatic bit grow_break(int unsigned incr, output int unsigned old);
    old = 0;
    if (brk > HEAP_LIMIT || incr > HEAP_LIMIT - brk) return 0;
    old = brk;
    brk = brk + incr;
    return 1;
  endfunction

  function automatic int unsigned coalesce(int unsigned bp);
    bit pa, na;
    int unsigned total;
    pa = used(prev_bp(bp) - 4);
    na = used(next_bp(bp) - 4);
    total = sz(bp - 4);
    if (pa && na) return bp;
    if (pa) begin
      total += sz(next_bp(bp) - 4);
      tag_wr(bp - 4, total);
      tag_wr(foot(bp), total);
    end else if (na) begin
      total += sz(prev_bp(bp) - 4);
      tag_wr(foot(bp), total);
      tag_wr(prev_bp(bp) - 4, total);
      bp = prev_bp(bp);
    end else begin
      total += sz(prev_bp(bp) - 4) + sz(next_bp(bp) - 4);
      tag_wr(prev_bp(bp) - 4, total);
      tag_wr(foot(next_bp(bp)), total);
      bp = prev_bp(bp);
    end
    return bp;
  endfunction

  function automatic bit grow_heap(int unsigned bytes, output int unsigned bp);
    int unsigned words;
    int unsigned total;
    bp = 0;
    words = bytes / 4;
    if (words & 1) words++;
    total = words * 4;
    if (!grow_break(total, bp)) return 0;
    tag_wr(bp - 4, total);
    tag_wr(foot(bp), total);
    tag_wr(next_bp(bp) - 4, 32'd1);
    bp = coalesce(bp);
    return 1;
  endfunction

  function automatic bit scan_free_block(int unsigned asize, output int unsigned found);
    int unsigned bp;
    int unsigned bsize;
    found = 0;
    bp = list_head;
    for (int unsigned steps = 0; steps < HEAP_WORDS; steps++) begin
      bsize = sz(bp - 4);
      if (bsize == 0) return 0;
      if (!used(bp - 4) && bsize >= asize) begin
        found = bp;
        return 1;
      end
      bp = next_bp(bp);
    end
    return 0;
  endfunction

  function automatic void place(int unsigned bp, int unsigned asize);
    int unsigned bsize;
    bsize = sz(bp - 4);
    if (bsize >= ilha_pkg::MIN_BLOCK + asize) begin
      tag_wr(bp - 4, asize | 1);
      tag_wr(foot(bp), asize | 1);
      bp = next_bp(bp);
      tag_wr(bp - 4, bsize - asize);
      tag_wr(foot(bp), bsize - asize);
    end else begin
      tag_wr(bp - 4, bsize | 1);
      tag_wr(foot(bp), bsize | 1);
    end
  endfunction

  function automatic alloc_result_t predict_heap_op(logic [1:0] m, logic [15:0] req,
                                                    logic [15:0] addr);
    alloc_result_t r;
    int unsigned bp, asize, want, bsize;
    r = '0;
    case (m)
      ilha_pkg::MODE_INIT: begin
        brk = 0;
        if (grow_break(16, bp)) begin
          tag_wr(bp, 32'd0);
          tag_wr(bp + 4, 32'd9);
          tag_wr(bp + 8, 32'd9);
          tag_wr(bp + 12, 32'd1);
          list_head = (bp + 8) & 16'hFFFF;
          if (grow_heap(CHUNK, bp)) r.ok = 1'b1;
        end
      end
      ilha_pkg::MODE_ALLOC: begin
        if (req != 0) begin
          asize = (req <= 8) ? 16 : (((int'(req) + 7) & ~7) + 8);
          if (scan_free_block(asize, bp)) begin
            place(bp, asize);
            r.payload = bp[15:0];
            r.ok = 1'b1;
          end else begin
            want = (CHUNK > asize) ? CHUNK : asize;
            if (grow_heap(want, bp)) begin
              place(bp, asize);
              r.payload = bp[15:0];
              r.ok = 1'b1;
            end
          end
        end
      end
      ilha_pkg::MODE_FREE: begin
        bsize = sz(int'(addr) - 4);
        tag_wr(int'(addr) - 4, bsize);
        tag_wr(foot(addr), bsize);
        void'(coalesce(addr));
        r.ok = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic mismatch_report(string what);
    errors++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // one item: drive, wait for acceptance, predict
  task automatic send_item(logic [1:0] m, logic [15:0] req, logic [15:0] addr);
    alloc_result_t exp_r;
    int unsigned gap;
    in_valid      <= 1'b1;
    mode          <= m;
    request_bytes <= req;
    block_address <= addr;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    exp_r = predict_heap_op(m, req, addr);
    pending_results.push_back(exp_r);
    items_sent++;
    case (m)
      ilha_pkg::MODE_INIT: begin
        live_blocks.delete();
        heap_ready = 1;
        n_init++;
      end
      ilha_pkg::MODE_ALLOC: begin
        if (exp_r.ok) begin
          live_blocks.push_back(32'(exp_r.payload));
          n_alloc_ok++;
        end else n_alloc_fail++;
      end
      ilha_pkg::MODE_FREE: n_free++;
      default: ;
    endcase
    gap = $urandom_range(0, 99);
    if (gap < 55) gap = 0;
    else if (gap < 95) gap = $urandom_range(1, 4);
    else gap = $urandom_range(10, 60);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic free_live(int unsigned idx);
    int unsigned a;
    a = live_blocks[idx];
    live_blocks.delete(idx);
    send_item(ilha_pkg::MODE_FREE, 16'($urandom), a[15:0]);
  endtask

  // the sender goes idle so the last item is not offered again
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver
  always @(posedge clk) begin
    int unsigned pick;
    if (rst || hold_off) out_ready <= 1'b0;
    else begin
      pick = $urandom_range(0, 99);
      out_ready <= (pick < 70) ? 1'b1 : (pick < 97 ? 1'b0 : ($urandom_range(0, 1) == 1));
    end
  end

  always @(negedge clk) begin
    alloc_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) mismatch_report("result with nothing expected");
      else begin
        exp_r = pending_results.pop_front();
        if (payload_address !== exp_r.payload)
          mismatch_report($sformatf("payload_address got %h want %h",
                                    payload_address, exp_r.payload));
        if (success !== exp_r.ok)
          mismatch_report($sformatf("success got %b want %b", success, exp_r.ok));
      end
    end
  end

  // long receiver hold-off, counted in cycles here
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      hold_off <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(2'd3, 16'hFFFF, 16'hFFFF);        // unused mode, before init
    send_item(ilha_pkg::MODE_INIT, 16'h0000, 16'h0000);
    send_item(ilha_pkg::MODE_ALLOC, 16'd0, 16'h0000);     // zero-size request
    send_item(ilha_pkg::MODE_ALLOC, 16'd1, 16'h0000);
    send_item(ilha_pkg::MODE_ALLOC, 16'd8, 16'h0000);
    send_item(ilha_pkg::MODE_ALLOC, 16'd9, 16'h0000);
    send_item(ilha_pkg::MODE_ALLOC, 16'd24, 16'h0000);
    send_item(ilha_pkg::MODE_ALLOC, 16'd100, 16'h0000);
    send_item(ilha_pkg::MODE_ALLOC, 16'hFFFF, 16'hFFFF);  // beyond the heap
    send_item(ilha_pkg::MODE_ALLOC, 16'd5000, 16'h0000);  // forces growth
    // coalescing: free the 9-byte block, then its left neighbor, then the 100-byte and 1-byte blocks
    free_live(2);
    free_live(1);
    free_live(2);
    free_live(0);
    send_item(ilha_pkg::MODE_ALLOC, 16'd40, 16'h0000);
    send_item(ilha_pkg::MODE_ALLOC, 16'd30000, 16'h0000);
    send_item(ilha_pkg::MODE_ALLOC, 16'd30000, 16'h0000); // should fail, heap too small
    send_item(2'd3, 16'h0000, 16'h0000);
    while (live_blocks.size() != 0) free_live(live_blocks.size() - 1);
    send_item(ilha_pkg::MODE_INIT, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic random_item();
    int unsigned pick, req, idx;
    pick = $urandom_range(0, 99);
    if (!heap_ready || pick < 2 || live_blocks.size() > 220) begin
      if (pick < 1) send_item(2'd3, 16'($urandom), 16'($urandom));
      else send_item(ilha_pkg::MODE_INIT, 16'($urandom), 16'($urandom));
    end else if (pick < 4) begin
      send_item(2'd3, 16'($urandom), 16'($urandom));
    end else if (pick < 40 && live_blocks.size() != 0) begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      free_live(idx);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 3) req = 0;
      else if (pick < 78) req = $urandom_range(1, 128);
      else if (pick < 95) req = $urandom_range(129, 6000);
      else req = $urandom_range(0, 65535);
      send_item(ilha_pkg::MODE_ALLOC, req[15:0], 16'($urandom));
    end
  endtask

  task automatic test_random(int unsigned count);
    repeat (count) random_item();
  endtask

  task automatic test_backpressure();
    hold_cycles <= 600;
    repeat (12) random_item();
  endtask

  task automatic test_sender_pause();
    wait_drained();
    repeat (6) random_item();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    mode = ilha_pkg::MODE_INIT;
    request_bytes = '0;
    block_address = '0;
    hold_off = 1'b0;
    hold_cycles = 0;
    heap_ready = 0;
    errors = 0; items_sent = 0; results_seen = 0; cycle_count = 0;
    n_alloc_ok = 0; n_alloc_fail = 0; n_free = 0; n_init = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(700);
    test_backpressure();
    test_sender_pause();
    test_random(850);
    in_valid <= 1'b0;
    wait_drained();
    repeat (100) @(posedge clk);
    $display("Ran %0d items: %0d inits, %0d allocs granted, %0d refused, %0d frees",
             items_sent, n_init, n_alloc_ok, n_alloc_fail, n_free);
    $display("Checked %0d results with %0d mismatches", results_seen, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ilha_pkg.sv
design/ilha_mem.sv
design/implicit_list_heap_allocator_core.sv
verif/testbench.sv
